[sv/gvg_pkg.sv]
// Shared constants, register codes and helper functions for the Gaussian value core.
package gvg_pkg;

    localparam int GVG_FRAC_BITS = 16;
    localparam int GVG_EXP_DEPTH = 1024;

    localparam int DATA_W  = 32;
    localparam int INV_W   = 31;
    localparam int E_W     = 17;
    localparam int SAT_IN_W = 64;

    localparam logic [63:0] LOG2E_Q24 = 64'd24204406;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;

    localparam logic [DATA_W-1:0] CENTER_RST = 32'd65536;
    localparam logic [INV_W-1:0]  INV_RST    = 31'd65536;
    localparam logic [DATA_W-1:0] PEAK_RST   = 32'd65536;

    typedef enum logic [1:0] {
        CFG_CENTER    = 2'd0,
        CFG_INV_WIDTH = 2'd1,
        CFG_PEAK      = 2'd2
    } t_cfg_idx;

    // Exponential table entry from its scaled squared index r = i*i*2^31/D^2.
    // Used only with constant arguments, so it folds to a constant at elaboration.
    function automatic logic [E_W-1:0] exp_entry(input logic [63:0] r);
        logic [63:0]        t;
        logic [63:0]        z;
        logic [63:0]        n;
        logic [63:0]        g;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        res;
        t    = r << 6;
        z    = (t * LOG2E_Q24) >> 24;
        n    = z >> 32;
        g    = ((z & 64'hFFFF_FFFF) * LN2_Q32) >> 32;
        term = 64'h1_0000_0000;
        sum  = 64'sh1_0000_0000;
        term = ((term * g) >> 32) / 64'd1;  sum = sum - $signed(term);
        term = ((term * g) >> 32) / 64'd2;  sum = sum + $signed(term);
        term = ((term * g) >> 32) / 64'd3;  sum = sum - $signed(term);
        term = ((term * g) >> 32) / 64'd4;  sum = sum + $signed(term);
        term = ((term * g) >> 32) / 64'd5;  sum = sum - $signed(term);
        term = ((term * g) >> 32) / 64'd6;  sum = sum + $signed(term);
        term = ((term * g) >> 32) / 64'd7;  sum = sum - $signed(term);
        term = ((term * g) >> 32) / 64'd8;  sum = sum + $signed(term);
        term = ((term * g) >> 32) / 64'd9;  sum = sum - $signed(term);
        term = ((term * g) >> 32) / 64'd10; sum = sum + $signed(term);
        term = ((term * g) >> 32) / 64'd11; sum = sum - $signed(term);
        term = ((term * g) >> 32) / 64'd12; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (n > 64'd40) begin
            res = 64'd0;
        end else begin
            res = ($unsigned(sum) + (64'd1 << (15 + n))) >> (16 + n);
        end
        return res[E_W-1:0];
    endfunction

    // Saturate a sign and magnitude pair to the signed 32-bit range.
    function automatic logic [DATA_W-1:0] sat32(input logic neg, input logic [SAT_IN_W-1:0] mag);
        logic [DATA_W-1:0] res;
        if (!neg) begin
            res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
        end else begin
            res = (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[DATA_W-1:0] + 32'd1);
        end
        return res;
    endfunction

endpackage

[sv/gaussian_value_and_gradients_core.sv]
// Pipelined Gaussian value, x-derivative and parameter gradients for one sample per cycle.
//
// Usage: an item (one Q16.16 sample) is taken at a rising edge where start is high and
// busy is low. busy is low whenever reset is released, so one item may enter every cycle.
// Each item yields exactly one result, shown on the o_ result ports for one cycle with
// o_strobe high, after it has passed through every stage; results leave in the
// order the items came. The receiver cannot stall, and no stage ever waits.
// Throughput is one item per cycle; the eight stages are the offset subtract, the
// scaling multiply, the table index and 1/sigma multiplies, the registered exponential
// ROM read, the amplitude multiply, the d/dmean multiply, the split d/dsigma multiply
// and the final sum and saturation.
// Configuration goes through its own valid/ready channel (index 0 center, 1 inv_width,
// 2 peak; other indexes are ignored). It is always ready and should be written only
// while no item is in flight. Reset is synchronous and active low: it empties the
// pipeline, so no strobe follows until new items arrive, and sets all three registers
// to 1.0. The exponential table has EXP_TABLE_DEPTH+1 entries spanning |y| in [0,8).
module gaussian_value_and_gradients_core #(
    parameter int FRAC_BITS       = gvg_pkg::GVG_FRAC_BITS,
    parameter int EXP_TABLE_DEPTH = gvg_pkg::GVG_EXP_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [gvg_pkg::DATA_W-1:0]    i_sample,
    output logic                                 o_strobe,
    output logic signed [gvg_pkg::DATA_W-1:0]    o_level,
    output logic signed [gvg_pkg::DATA_W-1:0]    o_slope_x,
    output logic        [gvg_pkg::E_W-1:0]       o_grad_peak,
    output logic signed [gvg_pkg::DATA_W-1:0]    o_grad_center,
    output logic signed [gvg_pkg::DATA_W-1:0]    o_grad_width,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [1:0]                    i_cfg_index,
    input  logic        [gvg_pkg::DATA_W-1:0]    i_cfg_data
);
    import gvg_pkg::*;

    localparam int NSTAGE   = 8;
    localparam int MY_W     = FRAC_BITS + 3;
    localparam int IDX_W    = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int IS_W     = MY_W + IDX_W + 1;
    localparam int W_W      = 34;
    localparam int PW_W     = MY_W + INV_W;
    localparam int GC_W     = 66 - FRAC_BITS;
    localparam int GCH_W    = GC_W - 32;
    localparam int GWL_W    = 32 + MY_W;
    localparam int GWH_W    = GCH_W + MY_W;
    localparam int GWS_W    = GC_W + MY_W;
    localparam logic [63:0] DEPTH_SQ = 64'(EXP_TABLE_DEPTH) * 64'(EXP_TABLE_DEPTH);
    localparam logic [IS_W-1:0] DEPTH_C = IS_W'(EXP_TABLE_DEPTH);
    localparam logic [IS_W-1:0] HALF_C  = IS_W'(1) << (FRAC_BITS + 2);

    // Exponential ROM, folded from constant entries.
    logic [E_W-1:0] exp_rom [EXP_TABLE_DEPTH+1];
    for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [63:0] R_VAL = ((64'(gi) * 64'(gi)) << 31) / DEPTH_SQ;
        assign exp_rom[gi] = exp_entry(R_VAL);
    end

    logic              accept;
    logic [NSTAGE-1:0] r_vld;

    logic signed [DATA_W-1:0] r_center;
    logic [INV_W-1:0]         r_inv;
    logic [DATA_W-1:0]        r_peak_mag;
    logic                     r_peak_neg;

    // Stage registers.
    logic [32:0]       r_s1_dmag;
    logic              r_s1_neg;
    logic [MY_W-1:0]   r_s2_my;
    logic              r_s2_far;
    logic              r_s2_neg;
    logic [IDX_W-1:0]  r_s3_idx;
    logic [W_W-1:0]    r_s3_w;
    logic [MY_W-1:0]   r_s3_my;
    logic              r_s3_far;
    logic              r_s3_neg;
    logic [E_W-1:0]    r_s4_e;
    logic [W_W-1:0]    r_s4_w;
    logic [MY_W-1:0]   r_s4_my;
    logic              r_s4_neg;
    logic [DATA_W-1:0] r_s5_ae;
    logic [E_W-1:0]    r_s5_e;
    logic [W_W-1:0]    r_s5_w;
    logic [MY_W-1:0]   r_s5_my;
    logic              r_s5_neg;
    logic [GC_W-1:0]   r_s6_gc;
    logic [DATA_W-1:0] r_s6_ae;
    logic [E_W-1:0]    r_s6_e;
    logic [MY_W-1:0]   r_s6_my;
    logic              r_s6_neg;
    logic [GWL_W-1:0]  r_s7_gw_lo;
    logic [GWH_W-1:0]  r_s7_gw_hi;
    logic [DATA_W-1:0] r_s7_level;
    logic [DATA_W-1:0] r_s7_gc;
    logic [DATA_W-1:0] r_s7_slope;
    logic [E_W-1:0]    r_s7_e;
    logic [DATA_W-1:0] r_level;
    logic [DATA_W-1:0] r_slope;
    logic [DATA_W-1:0] r_gc;
    logic [DATA_W-1:0] r_gw;
    logic [E_W-1:0]    r_e;

    // Next values.
    logic signed [32:0] diff;
    logic [32:0]        n_s1_dmag;
    logic [63:0]        prod_y;
    logic [IS_W-1:0]    idx_sum;
    logic [PW_W-1:0]    prod_w;
    logic [48:0]        prod_ae;
    logic [65:0]        prod_gc;
    logic [GWS_W-1:0]   gw_sum;
    logic [DATA_W-1:0]  n_cfg_peak_mag;

    assign accept      = start && !busy;
    assign busy        = !i_rst_n;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        diff      = 33'(i_sample) - 33'(r_center);
        n_s1_dmag = diff[32] ? (~diff + 33'd1) : diff;
        prod_y    = 64'(r_s1_dmag) * 64'(r_inv);
        idx_sum   = IS_W'(r_s2_my) * DEPTH_C + HALF_C;
        prod_w    = PW_W'(r_s2_my) * PW_W'(r_inv);
        prod_ae   = 49'(r_peak_mag) * 49'(r_s4_e);
        prod_gc   = 66'(r_s5_ae) * 66'(r_s5_w);
        gw_sum    = (GWS_W'(r_s7_gw_hi) << 32) + GWS_W'(r_s7_gw_lo);
        n_cfg_peak_mag = i_cfg_data[DATA_W-1] ? (~i_cfg_data + 32'd1) : i_cfg_data;
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_center   <= CENTER_RST;
            r_inv      <= INV_RST;
            r_peak_mag <= PEAK_RST;
            r_peak_neg <= 1'b0;
        end else begin
            r_vld <= {r_vld[NSTAGE-2:0], accept};
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_CENTER:    r_center <= i_cfg_data;
                    CFG_INV_WIDTH: r_inv    <= i_cfg_data[INV_W-1:0];
                    CFG_PEAK: begin
                        r_peak_mag <= n_cfg_peak_mag;
                        r_peak_neg <= i_cfg_data[DATA_W-1];
                    end
                    default: ;
                endcase
            end
        end
    end

    // Datapath. Beyond |y| >= 8 the table term is zero, which zeroes every output;
    // that keeps y to MY_W bits from stage two on.
    always_ff @(posedge i_clk) begin
        r_s1_dmag <= n_s1_dmag;
        r_s1_neg  <= diff[32];

        r_s2_my  <= prod_y[2*FRAC_BITS+2:FRAC_BITS];
        r_s2_far <= |prod_y[63:2*FRAC_BITS+3];
        r_s2_neg <= r_s1_neg;

        r_s3_idx <= idx_sum[MY_W+IDX_W-1:MY_W];
        r_s3_w   <= prod_w[FRAC_BITS+W_W-1:FRAC_BITS];
        r_s3_my  <= r_s2_my;
        r_s3_far <= r_s2_far;
        r_s3_neg <= r_s2_neg;

        r_s4_e   <= r_s3_far ? '0 : exp_rom[r_s3_idx];
        r_s4_w   <= r_s3_w;
        r_s4_my  <= r_s3_my;
        r_s4_neg <= r_s3_neg;

        r_s5_ae  <= prod_ae[47:16];
        r_s5_e   <= r_s4_e;
        r_s5_w   <= r_s4_w;
        r_s5_my  <= r_s4_my;
        r_s5_neg <= r_s4_neg;

        r_s6_gc  <= prod_gc[65:FRAC_BITS];
        r_s6_ae  <= r_s5_ae;
        r_s6_e   <= r_s5_e;
        r_s6_my  <= r_s5_my;
        r_s6_neg <= r_s5_neg;

        // d/dsigma carries the sign of the amplitude, since y enters twice.
        r_s7_gw_lo <= GWL_W'(r_s6_gc[31:0]) * GWL_W'(r_s6_my);
        r_s7_gw_hi <= GWH_W'(r_s6_gc[GC_W-1:32]) * GWH_W'(r_s6_my);
        r_s7_level <= sat32(r_peak_neg, SAT_IN_W'(r_s6_ae));
        r_s7_gc    <= sat32(r_peak_neg ^ r_s6_neg, SAT_IN_W'(r_s6_gc));
        r_s7_slope <= sat32(!(r_peak_neg ^ r_s6_neg), SAT_IN_W'(r_s6_gc));
        r_s7_e     <= r_s6_e;

        r_gw    <= sat32(r_peak_neg, SAT_IN_W'(gw_sum[GWS_W-1:FRAC_BITS]));
        r_level <= r_s7_level;
        r_gc    <= r_s7_gc;
        r_slope <= r_s7_slope;
        r_e     <= r_s7_e;
    end

    assign o_strobe      = r_vld[NSTAGE-1];
    assign o_level       = r_level;
    assign o_slope_x     = r_slope;
    assign o_grad_peak   = r_e;
    assign o_grad_center = r_gc;
    assign o_grad_width  = r_gw;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##8 o_strobe)
        else $error("item taken without a result eight cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 8))
        else $error("result strobe without a matching item");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_grad_peak <= 17'd65536))
        else $error("exponential term above one");

    a_zero_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_grad_peak == '0) |-> (o_level == '0 && o_slope_x == '0 &&
            o_grad_center == '0 && o_grad_width == '0))
        else $error("nonzero output with a zero exponential term");

    a_slope_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_grad_center != 32'sh7FFF_FFFF && o_grad_center != 32'sh8000_0000)
            |-> (o_slope_x == -o_grad_center))
        else $error("slope is not the negated mean gradient");
`endif

endmodule
